// ===== sv/tesrt_pkg.sv =====
// Shared types, codes and constants of the tab-expanding space-run tokenizer.
package tesrt_pkg;

	localparam int MAX_TAB_DEF     = 32;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int CFG_W           = 6;

	localparam logic [CFG_W-1:0] PEND_MAX = 6'd63;
	localparam logic [7:0]       CH_SPACE = 8'h20;
	localparam logic [7:0]       CH_TAB   = 8'h09;

	localparam logic REG_TAB_SIZE  = 1'b0;
	localparam logic REG_TAB_STOPS = 1'b1;

	typedef enum logic [1:0] {
		CMD_WS      = 2'd0,
		CMD_NEWLINE = 2'd1,
		CMD_TOKEN   = 2'd2,
		CMD_START   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD_TS,
		S_MOD_ST,
		S_TAB,
		S_DRAIN,
		S_FLUSH,
		S_TOKEN
	} state_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [CFG_W-1:0] ts;
		logic [CFG_W-1:0] stops;
	} cfg_t;

	// remainder unit status
	typedef struct packed {
		logic             done;
		logic [CFG_W-1:0] rem;
	} rem_res_t;

endpackage

// ===== sv/tesrt_regs.sv =====
// Configuration registers with APB write/read access and clamping of the tab settings.
module tesrt_regs #(
	parameter int MAX_TAB = tesrt_pkg::MAX_TAB_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output tesrt_pkg::cfg_t   cfg
);
	import tesrt_pkg::*;

	localparam int TS_LIM    = (MAX_TAB < 32) ? MAX_TAB : 32;
	localparam int STOPS_LIM = (MAX_TAB < 63) ? MAX_TAB : 63;

	logic [CFG_W-1:0] tab_size_q;
	logic [CFG_W-1:0] tab_stops_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_size_q  <= 6'd8;
			tab_stops_q <= 6'd8;
		end else if (wr_en) begin
			if (paddr[2] == REG_TAB_SIZE) begin
				tab_size_q <= pwdata[CFG_W-1:0];
			end else begin
				tab_stops_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_TAB_STOPS) begin
			prdata = {{(32-CFG_W){1'b0}}, tab_stops_q};
		end else begin
			prdata = {{(32-CFG_W){1'b0}}, tab_size_q};
		end
	end

	// zero acts as one, large values saturate
	always_comb begin
		if (tab_size_q == '0) begin
			cfg.ts = CFG_W'(1);
		end else if (tab_size_q > CFG_W'(TS_LIM)) begin
			cfg.ts = CFG_W'(TS_LIM);
		end else begin
			cfg.ts = tab_size_q;
		end
		if (tab_stops_q == '0) begin
			cfg.stops = CFG_W'(1);
		end else if (tab_stops_q > CFG_W'(STOPS_LIM)) begin
			cfg.stops = CFG_W'(STOPS_LIM);
		end else begin
			cfg.stops = tab_stops_q;
		end
	end

endmodule

// ===== sv/tesrt_rem.sv =====
// Bit-serial restoring remainder unit: column modulo a small divisor.
module tesrt_rem #(
	parameter int DIVIDEND_W = tesrt_pkg::COLUMN_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [DIVIDEND_W-1:0]   dividend,
	input  logic [tesrt_pkg::CFG_W-1:0] divisor,
	output tesrt_pkg::rem_res_t     res
);
	import tesrt_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [CFG_W-1:0]      dvs_q;
	logic [CFG_W-1:0]      part_q;
	logic [CFG_W:0]        trial;
	logic [CFG_W-1:0]      part_next;

	// partial remainder stays below the divisor, so trial fits one extra bit
	assign trial = {part_q, dvd_q[DIVIDEND_W-1]};

	always_comb begin
		if (trial >= {1'b0, dvs_q}) begin
			part_next = CFG_W'(trial - {1'b0, dvs_q});
		end else begin
			part_next = trial[CFG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			part_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
			part_q <= part_next;
		end
	end

	assign res.done = done_q;
	assign res.rem  = part_q;

endmodule

// ===== sv/tab_expand_space_run_tokenizer.sv =====
// Top level: token sequencer, column and pending-space state, result register.
// A space runs one remainder pass (column modulo tab_stops), a tab two (column modulo
// tab_size, then tab_stops) before its n expanded spaces; a newline or other token
// first flushes a pending run; the remainder unit is bit-serial, one column bit a cycle.
// One item at a time: s_axis_tready is high only between items, and a stalled result
// register holds the sequencer. Reset: arst_n clears column, pending spaces,
// sequencer and result valid; tab_size and tab_stops return to 8.
module tab_expand_space_run_tokenizer #(
	parameter int MAX_TAB     = tesrt_pkg::MAX_TAB_DEF,
	parameter int COLUMN_BITS = tesrt_pkg::COLUMN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// token input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // ws_char[7:0], action_code[23:8],
	                                   // token_length[39:24], token_ref[55:40]
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // out_action[15:0], out_length[31:16],
	                                   // out_ref[47:32]
	output logic        m_axis_tuser,  // is_space_run
	output logic        m_axis_tlast   // last
);
	import tesrt_pkg::*;

	cfg_t     cfg;
	rem_res_t res;

	state_t state_q, state_next;

	logic [COLUMN_BITS-1:0] col_q;
	logic [CFG_W-1:0]       pend_q;
	logic [CFG_W-1:0]       resid_q;
	logic [CFG_W-1:0]       cnt_q;
	logic                   hold_vld_q;
	logic [CFG_W-1:0]       hold_len_q;
	logic                   nl_q;
	logic [15:0]            act_q;
	logic [15:0]            len_q;
	logic [15:0]            ref_q;

	logic                   out_vld_q;
	logic                   out_run_q;
	logic                   out_last_q;
	logic [15:0]            out_act_q;
	logic [15:0]            out_len_q;
	logic [15:0]            out_ref_q;

	logic                   acc;
	cmd_t                   cmd;
	logic [7:0]             ws_char;
	logic                   is_space;
	logic                   is_tab;
	logic                   ofree;

	logic [CFG_W-1:0]       pend_inc;
	logic [COLUMN_BITS-1:0] col_inc;
	logic [CFG_W:0]         resid_inc;
	logic [CFG_W-1:0]       resid_next;
	logic                   emit;
	logic                   step;

	logic                   rem_start;
	logic [CFG_W-1:0]       rem_divisor;
	logic                   push;
	logic                   push_run;
	logic                   push_last;
	logic [15:0]            push_act;
	logic [15:0]            push_len;
	logic [15:0]            push_ref;

	tesrt_regs #(
		.MAX_TAB (MAX_TAB)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tesrt_rem #(
		.DIVIDEND_W (COLUMN_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (col_q),
		.divisor  (rem_divisor),
		.res      (res)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign acc      = s_axis_tvalid && s_axis_tready;
	assign cmd      = cmd_t'(s_axis_tuser);
	assign ws_char  = s_axis_tdata[7:0];
	assign is_space = (ws_char == CH_SPACE);
	assign is_tab   = (ws_char == CH_TAB);
	assign ofree    = !out_vld_q || m_axis_tready;

	// one added space: advance column and its residue modulo tab_stops
	assign pend_inc  = (pend_q == PEND_MAX) ? PEND_MAX : pend_q + CFG_W'(1);
	assign col_inc   = col_q + COLUMN_BITS'(1);
	assign resid_inc = {1'b0, resid_q} + (CFG_W+1)'(1);
	always_comb begin
		if (col_inc == '0 || resid_inc == {1'b0, cfg.stops}) begin
			resid_next = '0;
		end else begin
			resid_next = resid_inc[CFG_W-1:0];
		end
	end
	assign emit = (resid_next == '0);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (cmd)
						CMD_WS: begin
							if (is_space) begin
								state_next = S_MOD_ST;
							end else if (is_tab) begin
								state_next = S_MOD_TS;
							end
						end
						CMD_NEWLINE, CMD_TOKEN: begin
							state_next = (pend_q != '0) ? S_FLUSH : S_TOKEN;
						end
						default: state_next = S_IDLE;
					endcase
				end
			end
			S_MOD_TS: if (res.done) state_next = S_MOD_ST;
			S_MOD_ST: if (res.done) state_next = S_TAB;
			S_TAB:    if (step && cnt_q == CFG_W'(1)) state_next = S_DRAIN;
			S_DRAIN:  if (!hold_vld_q || ofree) state_next = S_IDLE;
			S_FLUSH:  if (ofree) state_next = S_TOKEN;
			S_TOKEN:  if (ofree) state_next = S_IDLE;
			default:  state_next = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		rem_start   = 1'b0;
		rem_divisor = cfg.stops;
		step        = 1'b0;
		push        = 1'b0;
		push_run    = 1'b1;
		push_last   = 1'b0;
		push_act    = '0;
		push_len    = {{(16-CFG_W){1'b0}}, pend_q};
		push_ref    = '0;
		case (state_q)
			S_IDLE: begin
				if (acc && cmd == CMD_WS && (is_space || is_tab)) begin
					rem_start   = 1'b1;
					rem_divisor = is_tab ? cfg.ts : cfg.stops;
				end
			end
			S_MOD_TS: begin
				rem_start = res.done;
			end
			S_TAB: begin
				// stall only when a held run must leave and the result register is full
				step     = !(emit && hold_vld_q && !ofree);
				push     = step && emit && hold_vld_q;
				push_len = {{(16-CFG_W){1'b0}}, hold_len_q};
			end
			S_DRAIN: begin
				push      = hold_vld_q && ofree;
				push_last = 1'b1;
				push_len  = {{(16-CFG_W){1'b0}}, hold_len_q};
			end
			S_FLUSH: begin
				push = ofree;
			end
			S_TOKEN: begin
				push      = ofree;
				push_run  = 1'b0;
				push_last = 1'b1;
				push_act  = act_q;
				push_len  = len_q;
				push_ref  = ref_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			col_q      <= '0;
			pend_q     <= '0;
			hold_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			case (state_q)
				S_IDLE: begin
					if (acc && cmd == CMD_START) begin
						col_q  <= '0;
						pend_q <= '0;
					end
				end
				S_TAB: begin
					if (step) begin
						col_q  <= col_inc;
						pend_q <= emit ? '0 : pend_inc;
						if (emit) hold_vld_q <= 1'b1;
					end
				end
				S_DRAIN: begin
					if (push) hold_vld_q <= 1'b0;
				end
				S_FLUSH: begin
					if (push) pend_q <= '0;
				end
				S_TOKEN: begin
					if (push) col_q <= nl_q ? '0 : col_q + COLUMN_BITS'(len_q);
				end
				default: ;
			endcase
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			nl_q  <= (cmd == CMD_NEWLINE);
			act_q <= s_axis_tdata[23:8];
			len_q <= s_axis_tdata[39:24];
			ref_q <= s_axis_tdata[55:40];
			cnt_q <= CFG_W'(1);
		end
		if (state_q == S_MOD_TS && res.done) begin
			cnt_q <= cfg.ts - res.rem;
		end
		if (state_q == S_MOD_ST && res.done) begin
			resid_q <= res.rem;
		end
		if (state_q == S_TAB && step) begin
			cnt_q   <= cnt_q - CFG_W'(1);
			resid_q <= resid_next;
			if (emit) hold_len_q <= pend_inc;
		end
		if (push) begin
			out_run_q  <= push_run;
			out_last_q <= push_last;
			out_act_q  <= push_act;
			out_len_q  <= push_len;
			out_ref_q  <= push_ref;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_ref_q, out_len_q, out_act_q};
	assign m_axis_tuser  = out_run_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== sv/tesrt_chk.sv =====
// Port-level checker for the tokenizer and its bind to the top level.
module tesrt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [55:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);
	import tesrt_pkg::*;

	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// a space run carries no action code and no handle
	a_run_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[47:32] == 16'd0)
		else $error("space run with nonzero action or handle");

	// start of text leaves the sequencer ready in the next cycle
	a_start_ready: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_axis_tuser == CMD_START |=> s_axis_tready)
		else $error("not ready after start command");

	// a passed token or a space keeps the sequencer busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (s_axis_tuser == CMD_NEWLINE || s_axis_tuser == CMD_TOKEN
			|| (s_axis_tuser == CMD_WS && s_axis_tdata[7:0] == CH_SPACE))
		|=> !s_axis_tready)
		else $error("ready right after an item that produces work");

endmodule

bind tab_expand_space_run_tokenizer tesrt_chk u_chk (.*);
